### rtl/dtwa_pkg.sv
// Shared types and constants of the table-driven DFA word acceptor.
package dtwa_pkg;

  localparam int unsigned STATE_W     = 4;
  localparam int unsigned SYMBOL_W    = 8;
  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned S_TDATA_W   = 24;
  localparam int unsigned M_TDATA_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 3;

  localparam logic REG_START_STATE = 1'b0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_TRANS  = 3'd0,
    OP_LOAD_ACCEPT = 3'd1,
    OP_LOAD_ALPHA  = 3'd2,
    OP_SYMBOL      = 3'd3,
    OP_EMPTY_WORD  = 3'd4
  } op_e;

  typedef struct packed {
    logic clear;
    logic take;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic room;
  } dp_sts_t;

  typedef struct packed {
    logic [STATE_W-1:0] final_state;
    logic               in_alphabet;
    logic               accepted;
  } result_t;

endpackage

### rtl/dtwa_ctrl.sv
// Controller state machine: clearing pass, item acceptance and symbol step sequencing.
module dtwa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  dtwa_pkg::op_e       opcode_i,
  input  dtwa_pkg::dp_sts_t   sts_i,
  output logic                in_ready_o,
  output dtwa_pkg::ctrl_cmd_t cmd_o
);
  import dtwa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_SYM   = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.room;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cmd_o.clear = 1'b0;
    cmd_o.take  = take;
    cmd_o.step  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take && (opcode_i == OP_SYMBOL)) begin
          state_d = S_SYM;
        end
      end
      S_SYM: begin
        cmd_o.step = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/dtwa_dpath.sv
// Datapath: transition memory, alphabet memory, accept marks, word state and result queue.
module dtwa_dpath #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_SYMBOLS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dtwa_pkg::ctrl_cmd_t               cmd_i,
  output dtwa_pkg::dp_sts_t                 sts_o,
  input  dtwa_pkg::op_e                     opcode_i,
  input  logic [dtwa_pkg::STATE_W-1:0]      from_state_i,
  input  logic [dtwa_pkg::SYMBOL_W-1:0]     symbol_i,
  input  logic [dtwa_pkg::STATE_W-1:0]      to_state_i,
  input  logic                              flag_i,
  input  logic                              last_i,
  input  logic [dtwa_pkg::STATE_W-1:0]      start_state_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output dtwa_pkg::result_t                 out_data_o
);
  import dtwa_pkg::*;

  localparam int unsigned DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned FW    = AW + STATE_W + SYMBOL_W;
  localparam int unsigned SW    = $clog2(NUM_STATES);
  localparam int unsigned YW    = $clog2(NUM_SYMBOLS);

  logic [STATE_W:0]          tbl_mem [DEPTH];
  logic                      alph_mem [NUM_SYMBOLS];
  logic                      acc_q [NUM_STATES];

  logic [AW-1:0]             clr_q;
  logic [STATE_W-1:0]        cur_q, cur_d;
  logic                      mid_q, mid_d;
  logic                      valid_q, valid_d;
  logic                      sym_ok_q, tbl_ok_q, last_q;
  logic [STATE_W:0]          tbl_rd_q;
  logic                      alph_rd_q;

  logic                      from_ok, sym_ok, base_ok;
  logic [STATE_W-1:0]        base;
  logic [FW-1:0]             wr_full, rd_full;
  logic [AW-1:0]             wr_idx, rd_idx;
  logic [YW-1:0]             sym_idx;
  logic [SW+STATE_W-1:0]     from_ext, start_ext, next_ext;
  logic                      start_acc, next_acc, start_ok, next_ok;
  logic [STATE_W-1:0]        next_state;
  logic                      next_valid;

  logic                      push;
  result_t                   push_data;
  logic                      out_vld_q, out_vld_d, skd_vld_q, skd_vld_d;
  result_t                   out_q, out_d, skd_q, skd_d;
  logic                      pop;

  assign from_ok = 32'(from_state_i) < NUM_STATES;
  assign sym_ok  = 32'(symbol_i) < NUM_SYMBOLS;
  assign base    = mid_q ? cur_q : start_state_i;
  assign base_ok = 32'(base) < NUM_STATES;

  assign wr_full = FW'(from_state_i) * FW'(NUM_SYMBOLS) + FW'(symbol_i);
  assign rd_full = FW'(base) * FW'(NUM_SYMBOLS) + FW'(symbol_i);
  assign wr_idx  = wr_full[AW-1:0];
  assign rd_idx  = rd_full[AW-1:0];
  assign sym_idx = symbol_i[YW-1:0];

  assign from_ext  = (SW + STATE_W)'(from_state_i);
  assign start_ext = (SW + STATE_W)'(start_state_i);
  assign start_ok  = 32'(start_state_i) < NUM_STATES;
  assign start_acc = start_ok && acc_q[start_ext[SW-1:0]];

  assign next_state = (tbl_ok_q && tbl_rd_q[STATE_W]) ? tbl_rd_q[STATE_W-1:0] : cur_q;
  assign next_valid = valid_q && sym_ok_q && alph_rd_q;
  assign next_ext   = (SW + STATE_W)'(next_state);
  assign next_ok    = 32'(next_state) < NUM_STATES;
  assign next_acc   = next_ok && acc_q[next_ext[SW-1:0]];

  assign sts_o.clear_last = (clr_q == AW'(DEPTH - 1));
  assign sts_o.room       = !skd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      tbl_mem[clr_q] <= '0;
    end else if (cmd_i.take && (opcode_i == OP_LOAD_TRANS) && from_ok && sym_ok) begin
      tbl_mem[wr_idx] <= {flag_i, to_state_i};
    end
    tbl_rd_q <= tbl_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (32'(clr_q) < NUM_SYMBOLS) begin
        alph_mem[clr_q[YW-1:0]] <= 1'b0;
      end
    end else if (cmd_i.take && (opcode_i == OP_LOAD_ALPHA) && sym_ok) begin
      alph_mem[sym_idx] <= flag_i;
    end
    alph_rd_q <= alph_mem[sym_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        acc_q[i] <= 1'b0;
      end
    end else if (cmd_i.take && (opcode_i == OP_LOAD_ACCEPT) && from_ok) begin
      acc_q[from_ext[SW-1:0]] <= flag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (opcode_i == OP_SYMBOL)) begin
      sym_ok_q <= sym_ok;
      tbl_ok_q <= base_ok && sym_ok;
      last_q   <= last_i;
    end
  end

  always_comb begin
    cur_d     = cur_q;
    mid_d     = mid_q;
    valid_d   = valid_q;
    push      = 1'b0;
    push_data = '{final_state: next_state, in_alphabet: next_valid, accepted: next_acc};
    if (cmd_i.step) begin
      cur_d   = next_state;
      valid_d = next_valid;
      mid_d   = !last_q;
      push    = last_q;
    end else if (cmd_i.take) begin
      case (opcode_i)
        OP_SYMBOL: begin
          cur_d = base;
          if (!mid_q) begin
            valid_d = 1'b1;
          end
        end
        OP_EMPTY_WORD: begin
          cur_d     = start_state_i;
          mid_d     = 1'b0;
          valid_d   = 1'b1;
          push      = 1'b1;
          push_data = '{final_state: start_state_i, in_alphabet: 1'b1, accepted: start_acc};
        end
        default: begin
          cur_d = cur_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      mid_q   <= 1'b0;
      valid_q <= 1'b1;
    end else begin
      cur_q   <= cur_d;
      mid_q   <= mid_d;
      valid_q <= valid_d;
    end
  end

  assign pop = out_vld_q && out_ready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    skd_vld_d = skd_vld_q;
    out_d     = out_q;
    skd_d     = skd_q;
    if (pop || !out_vld_q) begin
      if (skd_vld_q) begin
        out_d     = skd_q;
        out_vld_d = 1'b1;
        skd_vld_d = push;
        skd_d     = push_data;
      end else begin
        out_vld_d = push;
        out_d     = push_data;
      end
    end else if (push) begin
      skd_vld_d = 1'b1;
      skd_d     = push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skd_q <= skd_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skd_vld_q |-> out_vld_q)
    else $error("Skid entry holds a result while the output register is empty.");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_vld_q && !pop) |-> !skd_vld_q)
    else $error("Result pushed into a full result queue.");

  a_step_after_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> ($past(cmd_i.take) && ($past(opcode_i) == OP_SYMBOL)))
    else $error("Symbol step without a preceding symbol transfer.");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |-> !cmd_i.take)
    else $error("Item taken during the clearing pass.");
`endif

endmodule

### rtl/dfa_table_word_acceptor.sv
// Top level of the table-driven DFA word acceptor with its configuration register.
//
//   Port group   Direction  Role
//   s_axis_*     in         load items, word symbols and empty-word items
//   m_axis_*     out        one result per finished word
//   APB (p*)     in/out     start_state register at byte address 0
//
// After reset a clearing pass writes every transition entry, NUM_STATES * NUM_SYMBOLS
// of them (4096 at the defaults); no item is accepted until it ends.
// Load and empty-word items leave the controller in S_IDLE, ready for the next item.
// A word symbol then steps in S_SYM, where no item is taken, as the transition memory
// read is registered and its data is the next state and thus the next read address.
// A two-entry result queue lets items be accepted while a result waits on m_axis.
module dfa_table_word_acceptor #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_SYMBOLS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // from_state [3:0], symbol [11:4], to_state [15:12], flag [16], zeros [23:17].
  input  logic [dtwa_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // opcode [2:0].
  input  logic [dtwa_pkg::OPCODE_W-1:0]       s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // accepted [0], in_alphabet [1], final_state [5:2], zeros [7:6].
  output logic [dtwa_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dtwa_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [dtwa_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dtwa_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import dtwa_pkg::*;

  logic [STATE_W-1:0] start_q;
  logic               cfg_wr;
  op_e                opcode;
  ctrl_cmd_t          cmd;
  dp_sts_t            sts;
  result_t            res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_START_STATE);
  assign prdata = (paddr[2] == REG_START_STATE) ? CFG_DATA_W'(start_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_wr) begin
      start_q <= pwdata[STATE_W-1:0];
    end
  end

  assign opcode = op_e'(s_axis_tuser);

  dtwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (opcode),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  dtwa_dpath #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode),
    .from_state_i  (s_axis_tdata[3:0]),
    .symbol_i      (s_axis_tdata[11:4]),
    .to_state_i    (s_axis_tdata[15:12]),
    .flag_i        (s_axis_tdata[16]),
    .last_i        (s_axis_tlast),
    .start_state_i (start_q),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_data_o    (res)
  );

  assign m_axis_tdata = {2'b00, res.final_state, res.in_alphabet, res.accepted};

endmodule
